[src/tdc_hit_record_decoder_assert.svh]
// Assertion macros for the timing-readout record decoder.
// Included by the top level; depends on nothing else.
`ifndef TDC_HIT_RECORD_DECODER_ASSERT_SVH
`define TDC_HIT_RECORD_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TDCHRD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define TDCHRD_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define TDCHRD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define TDCHRD_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[src/tdchrd_pkg.sv]
// Shared types, codes and fixed-point constants of the record decoder.
// No dependencies.
package tdchrd_pkg;

  localparam int unsigned EVENT_RANGE_DEFAULT = 65536;

  // Configuration port.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_DROP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LOW_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_HIGH_MARK  = 2'd2;
  localparam logic [CFG_W-1:0] WRAP_DROP_RST       = 16'd20000;
  localparam logic [CFG_W-1:0] WRAP_LOW_WINDOW_RST = 16'd50;
  localparam logic [CFG_W-1:0] WRAP_HIGH_MARK_RST  = 16'd65530;

  typedef struct packed {
    logic [CFG_W-1:0] wrap_drop;
    logic [CFG_W-1:0] wrap_low_window;
    logic [CFG_W-1:0] wrap_high_mark;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_TIME = 2'd1,
    KIND_TEMP = 2'd2
  } kind_e;

  // Record classification.
  localparam logic [7:0]  GROUP1_BOARD     = 8'd12;
  localparam logic [7:0]  GROUP1_BOARD_OUT = 8'd11;
  localparam logic [7:0]  BOARD_GAP_LO     = 8'd8;
  localparam logic [7:0]  BOARD_GAP_HI     = 8'd20;
  localparam logic [15:0] CHAN_TIME        = 16'd100;
  localparam logic [15:0] CHAN_TEMP        = 16'd101;

  // Pipeline control.
  localparam int unsigned N_STAGES = 5;
  typedef struct packed {
    logic [N_STAGES-1:0] load;
    logic [N_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // Time arithmetic: counts times 400000, fine counts over 262143 = 2^18 - 1.
  localparam int unsigned TIME_P_W   = 52;
  localparam int unsigned TIME_W     = 53;
  localparam int unsigned WIDTH_W    = 54;
  localparam int unsigned FINE_Y_W   = 51;
  localparam int unsigned FINE_SHIFT = 18;
  localparam int unsigned QUOT_W     = 34;
  localparam logic signed [19:0] TICK_SCALE = 20'sd400000;
  // Half divisor for rounding plus 2^32 divisors, which keeps the dividend positive.
  localparam logic signed [TIME_P_W-1:0] Y_OFFSET = 52'sd1125895612006399;
  localparam logic signed [QUOT_W-1:0] QUOT_BIAS = 34'sd4294967296;

  // Temperature arithmetic.
  localparam int unsigned TEMP_P_W  = 59;
  localparam int unsigned TEMP_FRAC = 24;
  localparam logic signed [26:0] TEMP_GAIN = 27'sd33378403;
  // Offset 280.2308787 degC scaled by 2^32, with the half LSB for rounding folded in.
  localparam logic signed [TEMP_P_W-1:0] TEMP_OFFSET = -59'sd1203574070738;
  localparam logic signed [32:0] TEMP_REC_ROUND = 33'sd128;
  localparam int unsigned TEMP_REC_SHIFT = 8;

endpackage

[src/tdchrd_stream_if.sv]
// Valid/ready stream interfaces for raw records and decoded records.
// Depends on nothing but the field widths of the record formats.
interface tdchrd_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         board_raw;
  logic [15:0]        channel_raw;
  logic signed [31:0] word2;
  logic signed [31:0] word3;
  logic signed [31:0] word4;
  logic signed [31:0] word5;
  logic signed [31:0] word6;
  logic signed [31:0] word7;
  logic signed [31:0] word8;

  modport source (
    output valid, board_raw, channel_raw, word2, word3, word4, word5, word6, word7, word8,
    input  ready
  );
  modport sink (
    input  valid, board_raw, channel_raw, word2, word3, word4, word5, word6, word7, word8,
    output ready
  );
endinterface

interface tdchrd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic               group_id;
  logic [7:0]         board_out;
  logic [15:0]        channel_out;
  logic signed [47:0] event_extended;
  logic signed [55:0] arrival_time;
  logic signed [55:0] width_time;
  logic signed [31:0] fpga_temp;
  logic signed [31:0] sfp_temp;

  modport source (
    output valid, record_kind, group_id, board_out, channel_out, event_extended,
           arrival_time, width_time, fpga_temp, sfp_temp,
    input  ready
  );
  modport sink (
    input  valid, record_kind, group_id, board_out, channel_out, event_extended,
           arrival_time, width_time, fpga_temp, sfp_temp,
    output ready
  );
endinterface

[src/tdc_hit_record_decoder.sv]
// Top level of the timing-readout record decoder: five-stage decode pipeline.
// Depends on tdchrd_pkg, tdchrd_stream_if, tdchrd_pipe_ctrl, tdchrd_wrap_track,
// tdchrd_fine_div and the assertion macros in tdc_hit_record_decoder_assert.svh.
//
//   Channel  Direction  Handshake        Transaction
//   in_i     in         valid / ready    one raw nine-word record
//   out_o    out        valid / ready    one decoded record
//   cfg      in         cfg_we_i         cfg_idx_i selects a register, cfg_data_i is written
//
// One record can enter per cycle unless a stalled output has backed the pipeline up, and
// its decoded record passes an input register, three arithmetic stages and the output
// register. The wrap state of the record's group is read and written in the cycle that
// takes the record from the input register to the second stage, so back-to-back records
// of one group see each other. Every stage has its own valid bit and loads when empty or
// when it drains, so empty slots close up while the output is stalled. Reset clears valid
// bits, wrap state and the configuration registers to their defaults.

`include "tdc_hit_record_decoder_assert.svh"

module tdc_hit_record_decoder #(
  parameter int unsigned EVENT_RANGE = tdchrd_pkg::EVENT_RANGE_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tdchrd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tdchrd_pkg::CFG_W-1:0]       cfg_data_i,
  tdchrd_in_if.sink                          in_i,
  tdchrd_out_if.source                       out_o
);

  localparam int unsigned PW   = tdchrd_pkg::TIME_P_W;
  localparam int unsigned TW   = tdchrd_pkg::TIME_W;
  localparam int unsigned WW   = tdchrd_pkg::WIDTH_W;
  localparam int unsigned YW   = tdchrd_pkg::FINE_Y_W;
  localparam int unsigned QW   = tdchrd_pkg::QUOT_W;
  localparam int unsigned TPW  = tdchrd_pkg::TEMP_P_W;
  localparam int unsigned TF   = tdchrd_pkg::TEMP_FRAC;
  localparam int unsigned RS   = tdchrd_pkg::TEMP_REC_SHIFT;
  localparam int unsigned NS   = tdchrd_pkg::N_STAGES;

  // The wrap count times the event range, plus the signed event, needs EXT_W bits;
  // at least 49 so that the 48-bit saturation bounds are representable.
  localparam int unsigned ER_W   = $clog2(EVENT_RANGE + 1);
  localparam int unsigned PROD_W = 32 + ER_W;
  localparam int unsigned EXT_W  = (PROD_W + 2 > 49) ? PROD_W + 2 : 49;
  localparam logic signed [EXT_W-1:0] EV_MAX = EXT_W'((64'sd1 <<< 47) - 64'sd1);
  localparam logic signed [EXT_W-1:0] EV_MIN = EXT_W'(64'sd0 - (64'sd1 <<< 47));
  localparam logic signed [TF+10:0] TEMP_MAX = (TF + 11)'(64'sd2147483647);
  localparam logic signed [TF+10:0] TEMP_MIN = (TF + 11)'(-64'sd2147483648);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  tdchrd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_drop       <= tdchrd_pkg::WRAP_DROP_RST;
      cfg_q.wrap_low_window <= tdchrd_pkg::WRAP_LOW_WINDOW_RST;
      cfg_q.wrap_high_mark  <= tdchrd_pkg::WRAP_HIGH_MARK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdchrd_pkg::CFG_WRAP_DROP:       cfg_q.wrap_drop       <= cfg_data_i;
        tdchrd_pkg::CFG_WRAP_LOW_WINDOW: cfg_q.wrap_low_window <= cfg_data_i;
        tdchrd_pkg::CFG_WRAP_HIGH_MARK:  cfg_q.wrap_high_mark  <= cfg_data_i;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stage k loads when ctrl.load[k] is set.
  // ---------------------------------------------------------------------------
  tdchrd_pkg::pipe_ctrl_t ctrl;

  tdchrd_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  assign in_i.ready  = ctrl.load[0];
  assign out_o.valid = ctrl.valid[NS-1];

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [7:0]         s1_board_q;
  logic [15:0]        s1_chan_q;
  logic signed [31:0] s1_w2_q, s1_w3_q, s1_w4_q, s1_w5_q, s1_w6_q, s1_w7_q, s1_w8_q;

  // Classification. Only raw board 0 maps to board 0, so the raw number is tested.
  tdchrd_pkg::kind_e  s1_kind;
  logic               s1_group;
  logic [7:0]         s1_board_map;
  logic signed [31:0] s1_event;
  logic [31:0]        s1_wrap_count;

  always_comb begin
    if (s1_board_q == 8'd0 && s1_chan_q == tdchrd_pkg::CHAN_TEMP) begin
      s1_kind = tdchrd_pkg::KIND_TEMP;
    end else if (s1_board_q == 8'd0 && s1_chan_q == tdchrd_pkg::CHAN_TIME) begin
      s1_kind = tdchrd_pkg::KIND_TIME;
    end else begin
      s1_kind = tdchrd_pkg::KIND_HIT;
    end
  end

  assign s1_group = s1_board_q >= tdchrd_pkg::GROUP1_BOARD;

  // Boards 8 and 20 were never fitted; the numbers above each gap close up.
  always_comb begin
    if (s1_board_q > tdchrd_pkg::BOARD_GAP_LO && s1_board_q < tdchrd_pkg::BOARD_GAP_HI) begin
      s1_board_map = s1_board_q - 8'd1;
    end else if (s1_board_q > tdchrd_pkg::BOARD_GAP_HI) begin
      s1_board_map = s1_board_q - 8'd2;
    end else begin
      s1_board_map = s1_board_q;
    end
  end

  // A master time record carries its event in word 2, a hit in word 8.
  assign s1_event = (s1_kind == tdchrd_pkg::KIND_TIME) ? s1_w2_q : s1_w8_q;

  tdchrd_wrap_track u_wrap_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .update_i     (ctrl.valid[0] && ctrl.load[1] && (s1_kind != tdchrd_pkg::KIND_TEMP)),
    .group_i      (s1_group),
    .event_i      (s1_event),
    .wrap_count_o (s1_wrap_count)
  );

  // Coarse counts become 1/256 ps by the factor 400000 (1562.5 ps * 256). The fine
  // products get the rounding and positive bias added here, ahead of the divider.
  logic signed [PW-1:0]  s1_p2, s1_p4, s1_y3, s1_y5;
  logic signed [TPW-1:0] s1_tsum;
  logic signed [32:0]    s1_rec_f, s1_rec_s;

  assign s1_p2   = PW'(s1_w2_q) * PW'(tdchrd_pkg::TICK_SCALE);
  assign s1_p4   = PW'(s1_w4_q) * PW'(tdchrd_pkg::TICK_SCALE);
  assign s1_y3   = PW'(s1_w3_q) * PW'(tdchrd_pkg::TICK_SCALE) + tdchrd_pkg::Y_OFFSET;
  assign s1_y5   = PW'(s1_w5_q) * PW'(tdchrd_pkg::TICK_SCALE) + tdchrd_pkg::Y_OFFSET;
  assign s1_tsum = TPW'(s1_w6_q) * TPW'(tdchrd_pkg::TEMP_GAIN) + tdchrd_pkg::TEMP_OFFSET;

  // Temperature records hold 1/65536 degC; rounding to 1/256 degC.
  assign s1_rec_f = 33'(s1_w2_q) + tdchrd_pkg::TEMP_REC_ROUND;
  assign s1_rec_s = 33'(s1_w3_q) + tdchrd_pkg::TEMP_REC_ROUND;

  // ---------------------------------------------------------------------------
  // Stage 2
  // ---------------------------------------------------------------------------
  tdchrd_pkg::kind_e     s2_kind_q;
  logic                  s2_group_q;
  logic [7:0]            s2_board_q;
  logic [15:0]           s2_chan_q;
  logic signed [PW-1:0]  s2_p2_q, s2_p4_q;
  logic [YW-1:0]         s2_y3_q, s2_y5_q;
  logic signed [TPW-1:0] s2_tsum_q;
  logic signed [31:0]    s2_rec_f_q, s2_rec_s_q, s2_w7_q, s2_event_q;
  logic [31:0]           s2_wrap_count_q;

  logic signed [QW-1:0]    s2_q3, s2_q5;
  logic signed [TF+10:0]   s2_temp_shift;
  logic signed [31:0]      s2_temp_hit, s2_fpga, s2_sfp;
  logic [PROD_W-1:0]       s2_ev_prod;

  tdchrd_fine_div u_fine_div_lead (
    .y_i (s2_y3_q),
    .q_o (s2_q3)
  );

  tdchrd_fine_div u_fine_div_trail (
    .y_i (s2_y5_q),
    .q_o (s2_q5)
  );

  // FPGA sensor code scaled by 2^24 above 1/256 degC; drop the fraction and clamp.
  assign s2_temp_shift = $signed(s2_tsum_q[TPW-1:TF]);

  always_comb begin
    if (s2_temp_shift > TEMP_MAX) begin
      s2_temp_hit = 32'sh7fff_ffff;
    end else if (s2_temp_shift < TEMP_MIN) begin
      s2_temp_hit = 32'sh8000_0000;
    end else begin
      s2_temp_hit = 32'(s2_temp_shift);
    end
  end

  always_comb begin
    case (s2_kind_q)
      tdchrd_pkg::KIND_HIT: begin
        s2_fpga = s2_temp_hit;
        s2_sfp  = s2_w7_q;
      end
      tdchrd_pkg::KIND_TEMP: begin
        s2_fpga = s2_rec_f_q;
        s2_sfp  = s2_rec_s_q;
      end
      default: begin
        s2_fpga = '0;
        s2_sfp  = '0;
      end
    endcase
  end

  assign s2_ev_prod = PROD_W'(s2_wrap_count_q) * PROD_W'(EVENT_RANGE);

  // ---------------------------------------------------------------------------
  // Stage 3
  // ---------------------------------------------------------------------------
  tdchrd_pkg::kind_e    s3_kind_q;
  logic                 s3_group_q;
  logic [7:0]           s3_board_q;
  logic [15:0]          s3_chan_q;
  logic signed [PW-1:0] s3_p2_q, s3_p4_q;
  logic signed [QW-1:0] s3_q3_q, s3_q5_q;
  logic signed [31:0]   s3_fpga_q, s3_sfp_q, s3_event_q;
  logic [PROD_W-1:0]    s3_ev_prod_q;

  logic signed [TW-1:0]    s3_arrival, s3_trail;
  logic signed [EXT_W-1:0] s3_ev_sum;

  always_comb begin
    case (s3_kind_q)
      tdchrd_pkg::KIND_HIT:  s3_arrival = TW'(s3_p2_q) - TW'(s3_q3_q);
      tdchrd_pkg::KIND_TIME: s3_arrival = TW'(s3_p4_q);
      default:               s3_arrival = '0;
    endcase
  end

  assign s3_trail  = TW'(s3_p4_q) - TW'(s3_q5_q);
  assign s3_ev_sum = $signed(EXT_W'(s3_ev_prod_q)) + EXT_W'(s3_event_q);

  // ---------------------------------------------------------------------------
  // Stage 4
  // ---------------------------------------------------------------------------
  tdchrd_pkg::kind_e       s4_kind_q;
  logic                    s4_group_q;
  logic [7:0]              s4_board_q;
  logic [15:0]             s4_chan_q;
  logic signed [TW-1:0]    s4_arrival_q, s4_trail_q;
  logic signed [31:0]      s4_fpga_q, s4_sfp_q;
  logic signed [EXT_W-1:0] s4_ev_sum_q;

  logic signed [WW-1:0]    s4_width;
  logic signed [47:0]      s4_event_ext;

  assign s4_width = (s4_kind_q == tdchrd_pkg::KIND_HIT)
                    ? WW'(s4_trail_q) - WW'(s4_arrival_q) : '0;

  always_comb begin
    if (s4_kind_q == tdchrd_pkg::KIND_TEMP) begin
      s4_event_ext = '0;
    end else if (s4_ev_sum_q > EV_MAX) begin
      s4_event_ext = 48'(EV_MAX);
    end else if (s4_ev_sum_q < EV_MIN) begin
      s4_event_ext = 48'(EV_MIN);
    end else begin
      s4_event_ext = 48'(s4_ev_sum_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: output register
  // ---------------------------------------------------------------------------
  tdchrd_pkg::kind_e  s5_kind_q;
  logic               s5_group_q;
  logic [7:0]         s5_board_q;
  logic [15:0]        s5_chan_q;
  logic signed [47:0] s5_event_q;
  logic signed [55:0] s5_arrival_q, s5_width_q;
  logic signed [31:0] s5_fpga_q, s5_sfp_q;

  // Payload registers carry no reset; the valid bits in the pipeline control qualify them.
  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      s1_board_q <= in_i.board_raw;
      s1_chan_q  <= in_i.channel_raw;
      s1_w2_q    <= in_i.word2;
      s1_w3_q    <= in_i.word3;
      s1_w4_q    <= in_i.word4;
      s1_w5_q    <= in_i.word5;
      s1_w6_q    <= in_i.word6;
      s1_w7_q    <= in_i.word7;
      s1_w8_q    <= in_i.word8;
    end
    if (ctrl.load[1]) begin
      s2_kind_q       <= s1_kind;
      s2_group_q      <= s1_group;
      s2_board_q      <= s1_board_map;
      s2_chan_q       <= s1_chan_q;
      s2_p2_q         <= s1_p2;
      s2_p4_q         <= s1_p4;
      s2_y3_q         <= s1_y3[YW-1:0];
      s2_y5_q         <= s1_y5[YW-1:0];
      s2_tsum_q       <= s1_tsum;
      s2_rec_f_q      <= 32'($signed(s1_rec_f[32:RS]));
      s2_rec_s_q      <= 32'($signed(s1_rec_s[32:RS]));
      s2_w7_q         <= s1_w7_q;
      s2_event_q      <= s1_event;
      s2_wrap_count_q <= s1_wrap_count;
    end
    if (ctrl.load[2]) begin
      s3_kind_q    <= s2_kind_q;
      s3_group_q   <= s2_group_q;
      s3_board_q   <= s2_board_q;
      s3_chan_q    <= s2_chan_q;
      s3_p2_q      <= s2_p2_q;
      s3_p4_q      <= s2_p4_q;
      s3_q3_q      <= s2_q3;
      s3_q5_q      <= s2_q5;
      s3_fpga_q    <= s2_fpga;
      s3_sfp_q     <= s2_sfp;
      s3_event_q   <= s2_event_q;
      s3_ev_prod_q <= s2_ev_prod;
    end
    if (ctrl.load[3]) begin
      s4_kind_q    <= s3_kind_q;
      s4_group_q   <= s3_group_q;
      s4_board_q   <= s3_board_q;
      s4_chan_q    <= s3_chan_q;
      s4_arrival_q <= s3_arrival;
      s4_trail_q   <= s3_trail;
      s4_fpga_q    <= s3_fpga_q;
      s4_sfp_q     <= s3_sfp_q;
      s4_ev_sum_q  <= s3_ev_sum;
    end
    if (ctrl.load[4]) begin
      s5_kind_q    <= s4_kind_q;
      s5_group_q   <= s4_group_q;
      s5_board_q   <= s4_board_q;
      s5_chan_q    <= s4_chan_q;
      s5_event_q   <= s4_event_ext;
      s5_arrival_q <= 56'(s4_arrival_q);
      s5_width_q   <= 56'(s4_width);
      s5_fpga_q    <= s4_fpga_q;
      s5_sfp_q     <= s4_sfp_q;
    end
  end

  assign out_o.record_kind    = s5_kind_q;
  assign out_o.group_id       = s5_group_q;
  assign out_o.board_out      = s5_board_q;
  assign out_o.channel_out    = s5_chan_q;
  assign out_o.event_extended = s5_event_q;
  assign out_o.arrival_time   = s5_arrival_q;
  assign out_o.width_time     = s5_width_q;
  assign out_o.fpga_temp      = s5_fpga_q;
  assign out_o.sfp_temp       = s5_sfp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A temperature record comes only from board 0 and carries no event or time.
  `TDCHRD_ASSERT_IMP(a_temp_record_clean, clk_i, rst_ni, out_o.valid && out_o.record_kind == tdchrd_pkg::KIND_TEMP, out_o.board_out == 8'd0 && out_o.channel_out == tdchrd_pkg::CHAN_TEMP && out_o.event_extended == '0 && out_o.arrival_time == '0 && out_o.width_time == '0, "temperature record with nonzero event or time")
  // A master time record has no width and no temperatures.
  `TDCHRD_ASSERT_IMP(a_time_record_clean, clk_i, rst_ni, out_o.valid && out_o.record_kind == tdchrd_pkg::KIND_TIME, out_o.channel_out == tdchrd_pkg::CHAN_TIME && out_o.width_time == '0 && out_o.fpga_temp == '0 && out_o.sfp_temp == '0, "master time record with width or temperature")
  // The group split survives the board remap: group one starts at remapped board 11.
  `TDCHRD_ASSERT_IMP(a_group_matches_board, clk_i, rst_ni, out_o.valid, out_o.group_id == (out_o.board_out >= tdchrd_pkg::GROUP1_BOARD_OUT), "group does not match remapped board")

endmodule

[src/tdchrd_pipe_ctrl.sv]
// Valid bits and load enables of the decoder pipeline.
// Depends on tdchrd_pkg.
module tdchrd_pipe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  output tdchrd_pkg::pipe_ctrl_t ctrl_o
);

  localparam int unsigned N = tdchrd_pkg::N_STAGES;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] load;

  // A stage loads when it is empty or its content moves on, so bubbles fill up.
  assign load[N-1] = !valid_q[N-1] || out_ready_i;
  for (genvar k = 0; k < N - 1; k++) begin : g_load
    assign load[k] = !valid_q[k] || load[k+1];
  end

  assign valid_d = (load & {valid_q[N-2:0], in_valid_i}) | (~load & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;

endmodule

[src/tdchrd_wrap_track.sv]
// Per-group event wrap detection and saturating wrap counters.
// Depends on tdchrd_pkg.
module tdchrd_wrap_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdchrd_pkg::cfg_t   cfg_i,
  input  logic               update_i,
  input  logic               group_i,
  input  logic signed [31:0] event_i,
  output logic [31:0]        wrap_count_o
);

  logic signed [31:0] last_event_q [2];
  logic [31:0]        wrap_count_q [2];

  logic signed [31:0] prev_event;
  logic [31:0]        cur_count;
  logic signed [33:0] diff;
  logic signed [33:0] neg_drop;
  logic               drop_ok, low_ok, high_ok;

  assign prev_event = last_event_q[group_i];
  assign cur_count  = wrap_count_q[group_i];

  assign diff     = 34'(event_i) - 34'(prev_event);
  assign neg_drop = 34'sd0 - $signed({18'b0, cfg_i.wrap_drop});
  assign drop_ok  = diff < neg_drop;
  assign low_ok   = !event_i[31] && (event_i[30:0] < {15'b0, cfg_i.wrap_low_window});
  assign high_ok  = !prev_event[31] && (prev_event[30:0] > {15'b0, cfg_i.wrap_high_mark});

  assign wrap_count_o = (drop_ok && low_ok && high_ok && (cur_count != '1))
                        ? cur_count + 32'd1 : cur_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_event_q[0] <= '0;
      last_event_q[1] <= '0;
      wrap_count_q[0] <= '0;
      wrap_count_q[1] <= '0;
    end else if (update_i) begin
      last_event_q[group_i] <= event_i;
      wrap_count_q[group_i] <= wrap_count_o;
    end
  end

endmodule

[src/tdchrd_fine_div.sv]
// Rounded quotient of a biased fine-count product by 2^18 - 1, using adds only.
// Depends on tdchrd_pkg.
module tdchrd_fine_div (
  input  logic [tdchrd_pkg::FINE_Y_W-1:0]      y_i,
  output logic signed [tdchrd_pkg::QUOT_W-1:0] q_o
);

  localparam int unsigned SH  = tdchrd_pkg::FINE_SHIFT;
  localparam int unsigned YW  = tdchrd_pkg::FINE_Y_W;
  localparam int unsigned QW  = tdchrd_pkg::QUOT_W;
  localparam int unsigned A2W = YW - 2 * SH;
  localparam logic [SH+1:0] DIV  = (SH + 2)'((1 << SH) - 1);
  localparam logic [SH+1:0] DIV2 = (SH + 2)'(2 * ((1 << SH) - 1));

  logic [SH-1:0]  a0, a1;
  logic [A2W-1:0] a2;
  logic [SH+1:0]  digit_sum;
  logic [1:0]     corr;
  logic [QW-1:0]  q_u;

  // With 2^18 = d + 1, y = d * (a2 * 2^18 + a2 + a1) + (a0 + a1 + a2); the
  // digit sum stays below 3d, so at most two compares finish the quotient.
  assign a0 = y_i[SH-1:0];
  assign a1 = y_i[2*SH-1:SH];
  assign a2 = y_i[YW-1:2*SH];

  assign digit_sum = (SH + 2)'(a0) + (SH + 2)'(a1) + (SH + 2)'(a2);
  assign corr      = (digit_sum >= DIV2) ? 2'd2 : ((digit_sum >= DIV) ? 2'd1 : 2'd0);

  assign q_u = QW'({a2, {SH{1'b0}}}) + QW'(a2) + QW'(a1) + QW'(corr);
  assign q_o = $signed(q_u) - tdchrd_pkg::QUOT_BIAS;

endmodule

[tb/sv/tb_tdc_hit_record_decoder.sv]
// Self-checking testbench for the timing-readout record decoder: random and directed records
// are checked field by field against a behavioral decode with its own wrap-tracking state.
// Depends on tdchrd_pkg, the tdchrd_stream_if interfaces and the tdc_hit_record_decoder RTL.
module tb_tdc_hit_record_decoder;
  import tdchrd_pkg::*;

  // Fixed-point scaling of the decode: coarse counts become 1/256 ps at 400000 per count,
  // fine counts are a fraction of 2^18 - 1 steps, and the FPGA sensor code maps to
  // 1/256 degC through a gain and offset held at 2^24 scale.
  localparam longint TIME_TICK    = 400000;
  localparam longint FINE_STEPS   = 262143;
  localparam longint FPGA_GAIN    = 33378403;
  localparam longint FPGA_OFFSET  = 64'sd1203582459346;
  localparam longint FPGA_SCALE   = 16777216;
  localparam longint TEMP_SCALE   = 256;
  localparam longint EVENT_SPAN   = longint'(EVENT_RANGE_DEFAULT);
  localparam longint EVT_MAX      = 64'sd140737488355327;
  localparam longint EVT_MIN      = -64'sd140737488355328;
  localparam longint WORD_HI      = 64'sd2147483647;
  localparam longint WORD_LO      = -64'sd2147483648;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  // Index 3 selects no register; a write to it must leave the configuration alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned LONG_HOLD_AT   = 300;
  localparam int unsigned PHASE_ITEMS    = 350;
  localparam int unsigned PRINT_CAP      = 200;

  typedef struct packed {
    logic [7:0]         board_raw;
    logic [15:0]        channel_raw;
    logic signed [31:0] word2;
    logic signed [31:0] word3;
    logic signed [31:0] word4;
    logic signed [31:0] word5;
    logic signed [31:0] word6;
    logic signed [31:0] word7;
    logic signed [31:0] word8;
  } raw_record_t;

  typedef struct packed {
    kind_e              record_kind;
    logic               group_id;
    logic [7:0]         board_out;
    logic [15:0]        channel_out;
    logic signed [47:0] event_extended;
    logic signed [55:0] arrival_time;
    logic signed [55:0] width_time;
    logic signed [31:0] fpga_temp;
    logic signed [31:0] sfp_temp;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  tdchrd_in_if  rec_in ();
  tdchrd_out_if rec_out ();

  tdc_hit_record_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (rec_in),
    .out_o      (rec_out)
  );

  always #10 clk_i = ~clk_i;

  // Records waiting to be offered, and decoded records waiting to come out, oldest first.
  raw_record_t raw_records[$];
  decoded_t    decoded_due[$];

  // Shadow of the configuration registers and of the per-group wrap tracking state.
  logic [CFG_W-1:0] drop_shadow = WRAP_DROP_RST;
  logic [CFG_W-1:0] low_shadow  = WRAP_LOW_WINDOW_RST;
  logic [CFG_W-1:0] high_shadow = WRAP_HIGH_MARK_RST;
  int               last_evt[2] = '{0, 0};
  int unsigned      wrap_cnt[2] = '{0, 0};

  // Running event counters of the stimulus, one per group.
  int unsigned evt_run[2] = '{0, 0};

  int unsigned n_queued;
  int unsigned n_in_accepted;
  int unsigned n_mismatch;
  int unsigned idle_cycles;
  bit          in_fire_q;
  bit          calm;

  // ---------------------------------------------------------------------------------------
  // Behavioral decode.
  // ---------------------------------------------------------------------------------------

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Division rounded to nearest, ties toward plus infinity.
  function automatic longint round_div(input longint num, input longint den);
    return floor_div(2 * num + den, 2 * den);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // A wrap is counted only when the event falls far, lands in the low window and the
  // previous event sat above the high mark. Negative events never count as a wrap.
  function automatic longint extend_event(input bit grp, input longint evt);
    longint prev;
    prev = last_evt[grp];
    if (evt - prev < -longint'(drop_shadow) && evt >= 0 && evt < longint'(low_shadow) &&
        prev > longint'(high_shadow)) begin
      if (wrap_cnt[grp] != 32'hFFFF_FFFF) wrap_cnt[grp] = wrap_cnt[grp] + 1;
    end
    last_evt[grp] = int'(evt);
    return clamp(longint'(wrap_cnt[grp]) * EVENT_SPAN + evt, EVT_MIN, EVT_MAX);
  endfunction

  function automatic decoded_t decode_record(input raw_record_t r);
    decoded_t d;
    logic [7:0] brd;
    longint w2, w3, w4, w5, w6, w7, w8;
    longint lead, trail;
    w2 = r.word2;
    w3 = r.word3;
    w4 = r.word4;
    w5 = r.word5;
    w6 = r.word6;
    w7 = r.word7;
    w8 = r.word8;
    d = '0;
    d.group_id = (r.board_raw >= GROUP1_BOARD);
    // Boards 8 and 20 never existed, so the numbers above each gap close up by one.
    brd = r.board_raw;
    if (brd > BOARD_GAP_LO && brd < BOARD_GAP_HI) brd = brd - 8'd1;
    else if (brd > BOARD_GAP_HI) brd = brd - 8'd2;
    d.board_out = brd;
    d.channel_out = r.channel_raw;
    if (brd == 8'd0 && r.channel_raw == CHAN_TEMP) begin
      d.record_kind = KIND_TEMP;
      d.fpga_temp = 32'(round_div(w2, TEMP_SCALE));
      d.sfp_temp = 32'(round_div(w3, TEMP_SCALE));
    end else if (brd == 8'd0 && r.channel_raw == CHAN_TIME) begin
      d.record_kind = KIND_TIME;
      d.arrival_time = 56'(w4 * TIME_TICK);
      d.event_extended = 48'(extend_event(d.group_id, w2));
    end else begin
      d.record_kind = KIND_HIT;
      lead = w2 * TIME_TICK - round_div(w3 * TIME_TICK, FINE_STEPS);
      trail = w4 * TIME_TICK - round_div(w5 * TIME_TICK, FINE_STEPS);
      d.arrival_time = 56'(lead);
      d.width_time = 56'(trail - lead);
      d.fpga_temp = 32'(clamp(floor_div(w6 * FPGA_GAIN - FPGA_OFFSET + FPGA_SCALE / 2,
                                        FPGA_SCALE), WORD_LO, WORD_HI));
      d.sfp_temp = r.word7;
      d.event_extended = 48'(extend_event(d.group_id, w8));
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  task automatic queue_rec(input logic [7:0] brd, input logic [15:0] chan,
                           input logic signed [31:0] a2, input logic signed [31:0] a3,
                           input logic signed [31:0] a4, input logic signed [31:0] a5,
                           input logic signed [31:0] a6, input logic signed [31:0] a7,
                           input logic signed [31:0] a8);
    raw_records.insert(raw_records.size(), '{brd, chan, a2, a3, a4, a5, a6, a7, a8});
    n_queued++;
  endtask

  // Half of the words are fully random so every bit toggles; the rest stay in the range
  // that real counts and sensor codes occupy, so the arithmetic does not always saturate.
  function automatic logic signed [31:0] rand_word(input int unsigned span);
    logic signed [31:0] v;
    if ($urandom_range(0, 1) == 1) begin
      v = $urandom;
    end else begin
      v = $urandom_range(0, span);
      if ($urandom_range(0, 3) == 0) v = -v;
    end
    return v;
  endfunction

  // Event numbers mostly count up slowly and wrap modulo the event range; now and then the
  // counter jumps just below the top so wraps come often, steps back, or is replaced by noise.
  function automatic logic signed [31:0] next_event(input bit grp);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      evt_run[grp] = 65520 + $urandom_range(0, 15);
    end else if (pick < 7) begin
      return $urandom;
    end else if (pick < 10) begin
      evt_run[grp] = (evt_run[grp] + EVENT_RANGE_DEFAULT - $urandom_range(1, 3000)) %
                     EVENT_RANGE_DEFAULT;
    end else begin
      evt_run[grp] = (evt_run[grp] + $urandom_range(0, 3)) % EVENT_RANGE_DEFAULT;
    end
    return evt_run[grp];
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    logic [7:0] brd;
    logic [15:0] chan;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_rec(8'd0, CHAN_TEMP, rand_word(20000), rand_word(20000), $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      end else if (pick < 20) begin
        queue_rec(8'd0, CHAN_TIME, next_event(1'b0), $urandom, rand_word(1 << 24), $urandom,
                  $urandom, $urandom, $urandom);
      end else if (pick < 95) begin
        brd = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 31)) : 8'($urandom);
        if ($urandom_range(0, 19) == 0) chan = ($urandom_range(0, 1) == 1) ? CHAN_TIME : CHAN_TEMP;
        else chan = $urandom;
        queue_rec(brd, chan, rand_word(1 << 20), rand_word(FINE_STEPS), rand_word(1 << 20),
                  rand_word(FINE_STEPS), rand_word(1 << 21), $urandom,
                  next_event(brd >= GROUP1_BOARD));
      end else begin
        // Pure noise: every field random.
        queue_rec($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      end
    end
  endtask

  // One register write per call. The shadow copy changes at the same time, which is safe
  // because writes only happen while no record is inside the block.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_WRAP_DROP:       drop_shadow = val;
      CFG_WRAP_LOW_WINDOW: low_shadow = val;
      CFG_WRAP_HIGH_MARK:  high_shadow = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_wrap_cfg(input logic [CFG_W-1:0] drop, input logic [CFG_W-1:0] low,
                              input logic [CFG_W-1:0] high);
    write_reg(CFG_WRAP_DROP, drop);
    write_reg(CFG_WRAP_LOW_WINDOW, low);
    write_reg(CFG_WRAP_HIGH_MARK, high);
  endtask

  // Waits until every queued record went in and every decoded record came out, then lets
  // the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk_i); while (n_in_accepted != n_queued || decoded_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    n_mismatch++;
    // Printing stops after a while so a dead block cannot flood the log; counting goes on.
    if (n_mismatch <= PRINT_CAP)
      $display("mismatch #%0d on %s: got %0h, expected %0h", n_mismatch, what, got, want);
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rec_in.valid = 1'b0;
    rec_in.board_raw = '0;
    rec_in.channel_raw = '0;
    rec_in.word2 = '0;
    rec_in.word3 = '0;
    rec_in.word4 = '0;
    rec_in.word5 = '0;
    rec_in.word6 = '0;
    rec_in.word7 = '0;
    rec_in.word8 = '0;
    rec_out.ready = 1'b0;
    calm = 1'b0;
    n_queued = 0;
    n_in_accepted = 0;
    n_mismatch = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed records under the reset configuration.
    // Temperature records: extreme raw codes, and halves that must round upward.
    queue_rec(8'd0, CHAN_TEMP, WORD_MAX, WORD_MIN, 0, 0, 0, 0, 0);
    queue_rec(8'd0, CHAN_TEMP, -128, 128, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    queue_rec(8'd0, CHAN_TEMP, -129, 383, 0, 0, 0, 0, 0);
    // Master time records: a wrap of group 0 from just below the top to a small event.
    queue_rec(8'd0, CHAN_TIME, 65531, 0, WORD_MAX, 0, 0, 0, 0);
    queue_rec(8'd0, CHAN_TIME, 10, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    queue_rec(8'd0, CHAN_TIME, -1, 0, 0, 0, 0, 0, 0);
    // Hits: extreme counts, both saturations of the FPGA temperature, group 1 wrap.
    queue_rec(8'd12, 16'd0, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN, 65535);
    queue_rec(8'd255, 16'hFFFF, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX, 0);
    // Board numbers on and around the two gaps; channels 100 and 101 off board 0 are hits.
    queue_rec(8'd8, CHAN_TEMP, 1000, 131071, 1002, 131072, 36059, 6400, 5);
    queue_rec(8'd9, CHAN_TIME, 0, 0, 0, 0, 0, 0, 6);
    queue_rec(8'd11, 16'd7, 1, 1, 2, 262143, -1, -1, 7);
    queue_rec(8'd19, 16'd8, 5, 262143, 3, 0, 1, 1, 1);
    queue_rec(8'd20, 16'd9, -5, -262143, -3, 1, 2, 2, 2);
    queue_rec(8'd21, 16'd10, 7, 1, 9, 2, 3, 3, 3);
    queue_rec(8'd1, CHAN_TEMP, 0, 0, 0, 0, 0, 0, 8);
    queue_rec(8'd0, 16'd99, 0, 0, 0, 0, 0, 0, 9);
    queue_rec(8'd0, 16'd102, 123, 456, 789, 1011, 36060, 12, 10);
    // A huge event followed by zero counts as a wrap; the event range is not checked.
    queue_rec(8'd3, 16'd11, 0, 0, 0, 0, 0, 0, WORD_MAX);
    queue_rec(8'd3, 16'd12, 0, 0, 0, 0, 0, 0, 0);
    queue_rec(8'd13, 16'd13, 0, 0, 0, 0, 0, 0, WORD_MIN);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Loosest wrap condition: any fall from a positive event to a non-negative one below 65535 wraps.
    set_wrap_cfg(16'd0, 16'hFFFF, 16'd0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Tightest: an empty low window means nothing can wrap.
    set_wrap_cfg(16'hFFFF, 16'd0, 16'hFFFF);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Random settings, and a write to the unused index that must change nothing.
    set_wrap_cfg($urandom_range(0, 40000), $urandom_range(0, 65535), $urandom_range(0, 65535));
    write_reg(CFG_UNUSED_IDX, $urandom);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Final stretch at full rate on both sides, back at the reset configuration.
    calm = 1'b1;
    set_wrap_cfg(WRAP_DROP_RST, WRAP_LOW_WINDOW_RST, WRAP_HIGH_MARK_RST);
    queue_random(PHASE_ITEMS);
    wait_drained();

    if (n_mismatch == 0 && decoded_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Record driver: offers the next queued record at the falling edge, holds it until a
  // transaction takes it, and now and then goes idle.
  // ---------------------------------------------------------------------------------------

  int unsigned gap_left = 0;
  raw_record_t cur_rec;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rec_in.valid <= 1'b0;
    end else if (rec_in.valid && !in_fire_q) begin
      // Still waiting for the transaction; everything stays as it is.
    end else if (gap_left != 0) begin
      gap_left = gap_left - 1;
      rec_in.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(0, 4);
      rec_in.valid <= 1'b0;
    end else if (raw_records.size() != 0) begin
      cur_rec = raw_records.pop_front();
      rec_in.board_raw   <= cur_rec.board_raw;
      rec_in.channel_raw <= cur_rec.channel_raw;
      rec_in.word2       <= cur_rec.word2;
      rec_in.word3       <= cur_rec.word3;
      rec_in.word4       <= cur_rec.word4;
      rec_in.word5       <= cur_rec.word5;
      rec_in.word6       <= cur_rec.word6;
      rec_in.word7       <= cur_rec.word7;
      rec_in.word8       <= cur_rec.word8;
      rec_in.valid       <= 1'b1;
    end else begin
      rec_in.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result receiver: random stall bursts, plus one long hold-off once enough records went
  // in, so the pipeline fills and the block has to push back on its input.
  // ---------------------------------------------------------------------------------------

  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rec_out.ready <= 1'b0;
    end else if (!long_hold_done && n_in_accepted >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      rec_out.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      rec_out.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      rec_out.ready <= 1'b0;
    end else begin
      rec_out.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: at each rising edge a decoded-record transaction is checked against the oldest
  // expectation, and an input transaction is decoded into a new one. It also keeps the
  // watchdog, which ends the run when no transaction of either kind happens for too long.
  // ---------------------------------------------------------------------------------------

  decoded_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire_q = 1'b0;
      idle_cycles = 0;
    end else begin
      in_fire_q = rec_in.valid && rec_in.ready;
      if (rec_out.valid && rec_out.ready) begin
        if (decoded_due.size() == 0) begin
          log_mismatch("result with nothing expected", {rec_out.board_out, rec_out.channel_out},
                       '0);
        end else begin
          want = decoded_due.pop_front();
          if (rec_out.record_kind !== want.record_kind)
            log_mismatch("record_kind", rec_out.record_kind, want.record_kind);
          if (rec_out.group_id !== want.group_id)
            log_mismatch("group_id", rec_out.group_id, want.group_id);
          if (rec_out.board_out !== want.board_out)
            log_mismatch("board_out", rec_out.board_out, want.board_out);
          if (rec_out.channel_out !== want.channel_out)
            log_mismatch("channel_out", rec_out.channel_out, want.channel_out);
          if (rec_out.event_extended !== want.event_extended)
            log_mismatch("event_extended", rec_out.event_extended, want.event_extended);
          if (rec_out.arrival_time !== want.arrival_time)
            log_mismatch("arrival_time", rec_out.arrival_time, want.arrival_time);
          if (rec_out.width_time !== want.width_time)
            log_mismatch("width_time", rec_out.width_time, want.width_time);
          if (rec_out.fpga_temp !== want.fpga_temp)
            log_mismatch("fpga_temp", rec_out.fpga_temp, want.fpga_temp);
          if (rec_out.sfp_temp !== want.sfp_temp)
            log_mismatch("sfp_temp", rec_out.sfp_temp, want.sfp_temp);
        end
      end
      if (in_fire_q) begin
        decoded_due.insert(decoded_due.size(),
                           decode_record('{rec_in.board_raw, rec_in.channel_raw,
                                           rec_in.word2, rec_in.word3, rec_in.word4,
                                           rec_in.word5, rec_in.word6, rec_in.word7,
                                           rec_in.word8}));
        n_in_accepted++;
      end
      if (in_fire_q || (rec_out.valid && rec_out.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
